>>> design/pru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg: shared types and constants of the pixel replicating upscaler
// Field widths, register indexes and default limits.
// ----------------------------------------------------------------------------
package pru_pkg;

   localparam int COLOR_W     = 8;
   localparam int PIXEL_W     = 3 * COLOR_W;
   localparam int CFG_SCALE_W = 5;
   localparam int CFG_WIDTH_W = 12;
   localparam int CSR_DATA_W  = CFG_WIDTH_W;
   localparam int CSR_INDEX_W = 1;
   localparam int REPEAT_W    = 4;
   localparam int PAD_W       = 2;

   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_SCALE = 16;

   localparam logic [CFG_SCALE_W-1:0] SCALE_RESET = CFG_SCALE_W'(1);
   localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = CFG_WIDTH_W'(1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE = 1'b0,
      CSR_WIDTH = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_PIXEL  = 1'b0,
      MODE_REPLAY = 1'b1
   } mode_type;

   typedef logic [COLOR_W-1:0] color_type;

endpackage

>>> design/pru_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_if: channel interfaces of the pixel replicating upscaler
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pru_req_if;
   logic                 valid;
   logic                 ready;
   pru_pkg::mode_type    mode;
   pru_pkg::color_type   blue;
   pru_pkg::color_type   green;
   pru_pkg::color_type   red;

   modport source (output valid, mode, blue, green, red, input ready);
   modport sink   (input valid, mode, blue, green, red, output ready);
endinterface

interface pru_rsp_if;
   logic                              valid;
   logic                              ready;
   pru_pkg::color_type                out_blue;
   pru_pkg::color_type                out_green;
   pru_pkg::color_type                out_red;
   logic                              row_end;
   logic [pru_pkg::PAD_W-1:0]         pad_bytes;
   logic                              last;

   modport source (output valid, out_blue, out_green, out_red, row_end, pad_bytes, last,
                   input ready);
   modport sink   (input valid, out_blue, out_green, out_red, row_end, pad_bytes, last,
                   output ready);
endinterface

interface pru_csr_if;
   logic                               valid;
   logic                               ready;
   logic [pru_pkg::CSR_INDEX_W-1:0]    index;
   logic [pru_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/pixel_replicating_upscaler.sv
`timescale 1ns / 1ps
// Output: the first copy of a request is shown in the cycle after the request is taken.
// The single output register emits one copy per cycle while the response channel is ready,
// and the next request is taken in the cycle its last copy is taken.
// Reset: synchronous, active high; clears position, replay state and registers
// (scale = 1, width = 1). The line buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// pixel_replicating_upscaler: integer nearest-neighbor row enlargement
// Stores source pixels in a line buffer, emits each scale times and replays
// the buffered row scale-1 times, flagging row ends with the pad byte count.
// ----------------------------------------------------------------------------
module pixel_replicating_upscaler #(
   parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
   parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
   input logic     clock,
   input logic     reset,
   pru_req_if.sink   req_ch,
   pru_rsp_if.source rsp_ch,
   pru_csr_if.sink   csr_ch
);
   import pru_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int SW = $clog2(MAX_SCALE + 1);

   // configuration
   logic [CFG_SCALE_W-1:0] scale_ff;
   logic [CFG_WIDTH_W-1:0] width_ff;

   // row position and replay state
   logic [AW-1:0]       column_ff, column_in;
   logic [REPEAT_W-1:0] repeat_ff, repeat_in;
   logic                replaying_ff, replaying_in;

   // line buffer
   logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   // output register
   logic               busy_ff;
   logic [SW-1:0]      remain_ff;
   logic               from_mem_ff;
   logic [PIXEL_W-1:0] pix_ff;
   logic               row_end_ff;
   logic [PAD_W-1:0]   pad_ff;

   logic [SW-1:0]      eff_scale;
   logic [WW-1:0]      eff_width;
   logic [31:0]        scale32, width32;
   logic [PAD_W-1:0]   pad;
   logic [AW-1:0]      idx;
   logic               row_end;
   logic               req_take, pixel_ok, replay_ok, emit;
   logic               rsp_take, final_copy;
   logic [REPEAT_W-1:0] repeat_next;
   logic [PIXEL_W-1:0] req_pix, out_pix;

   // effective register values, clamped to the supported range
   always_comb begin
      if (scale_ff == '0) begin
         eff_scale = SW'(1);
      end else if (32'(scale_ff) > 32'(MAX_SCALE)) begin
         eff_scale = SW'(MAX_SCALE);
      end else begin
         eff_scale = SW'(scale_ff);
      end
      if (width_ff == '0) begin
         eff_width = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(width_ff);
      end
   end

   assign scale32 = 32'(eff_scale);
   assign width32 = 32'(eff_width);
   assign pad     = PAD_W'(width32[1:0] * scale32[1:0]);

   // a column at or past the last one ends the row
   always_comb begin
      if (32'(column_ff) >= width32 - 32'd1) begin
         idx     = AW'(width32 - 32'd1);
         row_end = 1'b1;
      end else begin
         idx     = column_ff;
         row_end = 1'b0;
      end
   end

   assign final_copy   = (remain_ff == '0);
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = !busy_ff || (rsp_ch.ready && final_copy);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign pixel_ok     = (req_ch.mode == MODE_PIXEL) && !replaying_ff;
   assign replay_ok    = (req_ch.mode == MODE_REPLAY) && replaying_ff;
   // drop requests in the wrong phase
   assign emit         = req_take && (pixel_ok || replay_ok);
   assign req_pix      = {req_ch.red, req_ch.green, req_ch.blue};
   assign repeat_next  = repeat_ff + REPEAT_W'(1);

   // next row position and replay state
   always_comb begin
      column_in    = column_ff;
      repeat_in    = repeat_ff;
      replaying_in = replaying_ff;
      if (emit) begin
         if (!row_end) begin
            column_in = idx + AW'(1);
         end else begin
            column_in = '0;
            if (pixel_ok) begin
               repeat_in    = '0;
               replaying_in = (eff_scale > SW'(1));
            end else if (repeat_next == '0 ||
                         32'(repeat_next) >= scale32 - 32'd1) begin
               repeat_in    = '0;
               replaying_in = 1'b0;
            end else begin
               repeat_in = repeat_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         repeat_ff    <= '0;
         replaying_ff <= 1'b0;
      end else begin
         column_ff    <= column_in;
         repeat_ff    <= repeat_in;
         replaying_ff <= replaying_in;
      end
   end

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         width_ff <= WIDTH_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_index_type'(csr_ch.index))
            CSR_SCALE: scale_ff <= csr_ch.data[CFG_SCALE_W-1:0];
            CSR_WIDTH: width_ff <= csr_ch.data[CFG_WIDTH_W-1:0];
            default:   ;
         endcase
      end
   end

   // line buffer: write source pixels, read on replay; read data held until the next read
   always_ff @(posedge clock) begin
      if (emit && pixel_ok) begin
         line_mem[idx] <= req_pix;
      end
      if (emit && replay_ok) begin
         rd_data_ff <= line_mem[idx];
      end
   end

   // output register: one copy per cycle while the response channel is ready
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         remain_ff <= '0;
      end else if (emit) begin
         busy_ff   <= 1'b1;
         remain_ff <= eff_scale - SW'(1);
      end else if (rsp_take) begin
         if (final_copy) begin
            busy_ff <= 1'b0;
         end else begin
            remain_ff <= remain_ff - SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         from_mem_ff <= replay_ok;
         pix_ff      <= req_pix;
         row_end_ff  <= row_end;
         pad_ff      <= pad;
      end
   end

   assign out_pix          = from_mem_ff ? rd_data_ff : pix_ff;
   assign rsp_ch.valid     = busy_ff;
   assign rsp_ch.out_blue  = out_pix[COLOR_W-1:0];
   assign rsp_ch.out_green = out_pix[2*COLOR_W-1:COLOR_W];
   assign rsp_ch.out_red   = out_pix[PIXEL_W-1:2*COLOR_W];
   assign rsp_ch.row_end   = final_copy && row_end_ff;
   assign rsp_ch.pad_bytes = (final_copy && row_end_ff) ? pad_ff : '0;
   assign rsp_ch.last      = final_copy;

endmodule
